FILE: src/lcf_pkg.sv
package lcf_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_TAN_MIN      = 3'd0,
    REG_TAN_MAX      = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_KEEP_COUNT   = 3'd4
  } reg_idx_e;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_PROD,
    ST_SUMS,
    ST_ANGLE,
    ST_POINT,
    ST_RANGE,
    ST_DIV,
    ST_EMIT,
    ST_STORE
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_seg;
    logic rd_mem;
    logic do_prod;
    logic do_sums;
    logic do_angle;
    logic do_point;
    logic do_range;
    logic div_start;
    logic div_step;
    logic pend_load;
    logic out_load;
    logic wr_mem;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic pass;
    logic div_done;
  } stat_t;

endpackage

FILE: src/lcf_if.sv
interface lcf_seg_if #(parameter int CoordBits = 12);
  logic                 valid;
  logic                 ready;
  logic [CoordBits-1:0] start_x;
  logic [CoordBits-1:0] start_y;
  logic [CoordBits-1:0] end_x;
  logic [CoordBits-1:0] end_y;
  logic                 new_frame;
  modport source(output valid, start_x, start_y, end_x, end_y, new_frame, input ready);
  modport sink(input valid, start_x, start_y, end_x, end_y, new_frame, output ready);
endinterface

interface lcf_cross_if;
  logic        valid;
  logic        ready;
  logic [15:0] cross_x;
  logic [15:0] cross_y;
  logic [5:0]  partner_index;
  logic        last_of_run;
  modport source(output valid, cross_x, cross_y, partner_index, last_of_run, input ready);
  modport sink(input valid, cross_x, cross_y, partner_index, last_of_run, output ready);
endinterface

FILE: src/lcf_datapath.sv
module lcf_datapath #(
  parameter int SegMax    = 64,
  parameter int CoordBits = 12
) (
  input  logic                    clk_i,
  input  lcf_pkg::cmd_t           cmd_i,
  output lcf_pkg::stat_t          stat_o,
  input  logic [$clog2(SegMax)-1:0] rd_idx_i,
  input  logic [$clog2(SegMax)-1:0] wr_idx_i,
  input  logic [CoordBits-1:0]    sx_i,
  input  logic [CoordBits-1:0]    sy_i,
  input  logic [CoordBits-1:0]    ex_i,
  input  logic [CoordBits-1:0]    ey_i,
  input  logic [15:0]             tan_min_i,
  input  logic [15:0]             tan_max_i,
  input  logic [12:0]             width_i,
  input  logic [12:0]             height_i,
  output logic [15:0]             px_o,
  output logic [15:0]             py_o
);
  import lcf_pkg::*;

  localparam int CB = CoordBits;
  localparam int DB = CB + 1;          // difference width, signed
  localparam int PB = 2 * DB;          // product width
  localparam int SB = PB + 1;          // sum of two products
  localparam int NB = SB + DB + 2;     // numerator times direction plus offset
  localparam int QB = 17;              // quotient bits, saturating to 16
  localparam int MB = 4 * CB;

  // Segment store, read data registered.
  logic [MB-1:0] mem [SegMax];
  logic [MB-1:0] rd_q;
  logic [CB-1:0] nx1_q, ny1_q, nx2_q, ny2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_mem) begin
      mem[wr_idx_i] <= {nx1_q, ny1_q, nx2_q, ny2_q};
    end
    if (cmd_i.rd_mem) begin
      rd_q <= mem[rd_idx_i];
    end
    if (cmd_i.load_seg) begin
      nx1_q <= sx_i;
      ny1_q <= sy_i;
      nx2_q <= ex_i;
      ny2_q <= ey_i;
    end
  end

  logic signed [DB-1:0] ax1, ay1, ux, uy, vx, vy, wx, wy;
  assign ax1 = signed'({1'b0, rd_q[4*CB-1:3*CB]});
  assign ay1 = signed'({1'b0, rd_q[3*CB-1:2*CB]});
  assign ux  = signed'({1'b0, rd_q[2*CB-1:CB]}) - ax1;
  assign uy  = signed'({1'b0, rd_q[CB-1:0]}) - ay1;
  assign vx  = signed'({1'b0, nx2_q}) - signed'({1'b0, nx1_q});
  assign vy  = signed'({1'b0, ny2_q}) - signed'({1'b0, ny1_q});
  assign wx  = ax1 - signed'({1'b0, nx1_q});
  assign wy  = ay1 - signed'({1'b0, ny1_q});

  // Stage 1: six products (d equals cross, so only cross is formed).
  logic signed [PB-1:0] p_uxvx_q, p_uyvy_q, p_uxvy_q, p_uyvx_q, p_wxvy_q, p_wyvx_q;
  logic signed [DB-1:0] ux_q, uy_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_prod) begin
      p_uxvx_q <= ux * vx;
      p_uyvy_q <= uy * vy;
      p_uxvy_q <= ux * vy;
      p_uyvx_q <= uy * vx;
      p_wxvy_q <= wx * vy;
      p_wyvx_q <= wy * vx;
      ux_q <= ux;
      uy_q <= uy;
    end
  end

  // Stage 2: dot, cross and numerator; normalize sign so d >= 0.
  logic [SB-1:0]        adot_q, d_q;
  logic signed [SB:0]   num_q;
  logic                 dzero_q;
  logic signed [SB-1:0] dot_w, crs_w, num_w;
  assign dot_w = SB'(p_uxvx_q) + SB'(p_uyvy_q);
  assign crs_w = SB'(p_uxvy_q) - SB'(p_uyvx_q);
  assign num_w = -(SB'(p_wxvy_q) - SB'(p_wyvx_q));
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_sums) begin
      adot_q  <= dot_w[SB-1] ? SB'(-dot_w) : SB'(dot_w);
      d_q     <= crs_w[SB-1] ? SB'(-crs_w) : SB'(crs_w);
      num_q   <= crs_w[SB-1] ? -(SB+1)'(num_w) : (SB+1)'(num_w);
      dzero_q <= (crs_w == '0);
    end
  end

  // Stage 3: angle window, one multiplier per bound.
  localparam int AB = SB + 16;
  logic [AB-1:0] lo_q, hi_q, mid_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_angle) begin
      lo_q  <= AB'(tan_min_i) * AB'(adot_q);
      hi_q  <= AB'(tan_max_i) * AB'(adot_q);
      mid_q <= AB'({d_q, 8'd0});
    end
  end
  logic angle_ok;
  assign angle_ok = (lo_q <= mid_q) && (mid_q <= hi_q) && !dzero_q;

  // Stage 4: point numerators.
  logic signed [NB-1:0] nx_q, ny_q;
  logic                 ok_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_point) begin
      nx_q <= NB'(ax1) * NB'(signed'({1'b0, d_q})) + NB'(num_q) * NB'(ux_q);
      ny_q <= NB'(ay1) * NB'(signed'({1'b0, d_q})) + NB'(num_q) * NB'(uy_q);
      ok_q <= angle_ok;
    end
  end

  // Stage 5: image bounds, formed alongside the point numerators.
  logic signed [NB-1:0] wl_q, hl_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_range) begin
      wl_q <= NB'(width_i) * NB'(d_q);
      hl_q <= NB'(height_i) * NB'(d_q);
    end
  end
  assign stat_o.pass = ok_q && !nx_q[NB-1] && !ny_q[NB-1] && (nx_q < wl_q) && (ny_q < hl_q);

  // Restoring divider, both coordinates in parallel, one quotient bit per step.
  localparam int RB = SB + 1;
  logic [NB+3:0]         dvx_q, dvy_q;
  logic [RB-1:0]         rx_q, ry_q;
  logic [QB-1:0]         qx_q, qy_q;
  logic [$clog2(NB+5)-1:0] cnt_q;
  logic [RB-1:0]         rx_t, ry_t;
  assign rx_t = {rx_q[RB-2:0], dvx_q[NB+3]};
  assign ry_t = {ry_q[RB-2:0], dvy_q[NB+3]};
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvx_q <= {nx_q, 4'd0};
      dvy_q <= {ny_q, 4'd0};
      rx_q  <= '0;
      ry_q  <= '0;
      qx_q  <= '0;
      qy_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dvx_q <= dvx_q << 1;
      dvy_q <= dvy_q << 1;
      cnt_q <= cnt_q + 1'b1;
      if (rx_t >= RB'(d_q)) begin
        rx_q <= rx_t - RB'(d_q);
        qx_q <= {qx_q[QB-2:0], 1'b1};
      end else begin
        rx_q <= rx_t;
        qx_q <= {qx_q[QB-2:0], 1'b0};
      end
      if (ry_t >= RB'(d_q)) begin
        ry_q <= ry_t - RB'(d_q);
        qy_q <= {qy_q[QB-2:0], 1'b1};
      end else begin
        ry_q <= ry_t;
        qy_q <= {qy_q[QB-2:0], 1'b0};
      end
    end
  end
  assign stat_o.div_done = (32'(cnt_q) == NB + 4);

  // Saturated point waits in a holding register until the controller releases it.
  logic [15:0] pend_px_q, pend_py_q;
  logic [15:0] px_q, py_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_load) begin
      pend_px_q <= qx_q[QB-1] ? 16'hFFFF : qx_q[15:0];
      pend_py_q <= qy_q[QB-1] ? 16'hFFFF : qy_q[15:0];
    end
    if (cmd_i.out_load) begin
      px_q <= pend_px_q;
      py_q <= pend_py_q;
    end
  end
  assign px_o = px_q;
  assign py_o = py_q;
endmodule

FILE: src/lcf_ctrl.sv
module lcf_ctrl #(
  parameter int SegMax = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      new_frame_i,
  input  logic [6:0]                keep_count_i,
  input  lcf_pkg::stat_t            stat_i,
  output lcf_pkg::cmd_t             cmd_o,
  output logic [$clog2(SegMax)-1:0] rd_idx_o,
  output logic [$clog2(SegMax)-1:0] wr_idx_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [5:0]                partner_o,
  output logic                      last_o
);
  import lcf_pkg::*;

  localparam int IB = $clog2(SegMax);

  state_e      state_q, state_d;
  logic [6:0]  count_q, count_d;
  logic [6:0]  j_q, j_d;
  logic        out_valid_q, out_valid_d;
  logic        pend_q, pend_d;
  logic [5:0]  pend_idx_q, pend_idx_d;
  logic [5:0]  partner_q;
  logic        last_q;
  logic [6:0]  limit, cnt_eff;
  logic        accept, slot_free;

  assign limit     = (keep_count_i < 7'(SegMax)) ? keep_count_i : 7'(SegMax);
  assign cnt_eff   = new_frame_i ? 7'd0 : count_q;
  assign in_ready_o = (state_q == ST_IDLE) && !pend_q;
  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign rd_idx_o  = j_q[IB-1:0];
  assign wr_idx_o  = count_q[IB-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    j_d     = j_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          count_d = cnt_eff;
          j_d     = '0;
          if (cnt_eff >= limit) begin
            state_d = ST_IDLE;
          end else if (cnt_eff == 7'd0) begin
            state_d = ST_STORE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ:  state_d = ST_PROD;
      ST_PROD:  state_d = ST_SUMS;
      ST_SUMS:  state_d = ST_ANGLE;
      ST_ANGLE: state_d = ST_POINT;
      ST_POINT: state_d = ST_RANGE;
      ST_RANGE: begin
        if (stat_i.pass) begin
          state_d = ST_DIV;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = (j_q + 1'b1 >= count_q) ? ST_STORE : ST_READ;
        end
      end
      ST_DIV:   if (stat_i.div_done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          j_d     = j_q + 1'b1;
          state_d = (j_q + 1'b1 >= count_q) ? ST_STORE : ST_READ;
        end
      end
      ST_STORE: begin
        if (slot_free) begin
          count_d = count_q + 1'b1;
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs and result holding.
  always_comb begin
    cmd_o            = '0;
    out_valid_d      = out_valid_q && !out_ready_i;
    pend_d           = pend_q;
    pend_idx_d       = pend_idx_q;
    cmd_o.load_seg   = accept;
    unique case (state_q)
      ST_READ:  cmd_o.rd_mem   = 1'b1;
      ST_PROD:  cmd_o.do_prod  = 1'b1;
      ST_SUMS:  cmd_o.do_sums  = 1'b1;
      ST_ANGLE: cmd_o.do_angle = 1'b1;
      ST_POINT: begin
        cmd_o.do_point = 1'b1;
        cmd_o.do_range = 1'b1;
      end
      ST_RANGE: cmd_o.div_start = stat_i.pass;
      ST_DIV:   cmd_o.div_step = !stat_i.div_done;
      ST_EMIT: begin
        // A crossing waits here; the previous one is sent when the next is known.
        if (slot_free) begin
          cmd_o.pend_load = 1'b1;
          cmd_o.out_load  = pend_q;
          out_valid_d     = pend_q;
          pend_d          = 1'b1;
          pend_idx_d      = 6'(j_q);
        end
      end
      ST_STORE: begin
        if (slot_free) begin
          cmd_o.wr_mem   = 1'b1;
          cmd_o.out_load = pend_q;
          out_valid_d    = pend_q;
          pend_d         = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    if (slot_free && pend_q && (state_q == ST_EMIT || state_q == ST_STORE)) begin
      partner_q <= pend_idx_q;
      last_q    <= (state_q == ST_STORE);
    end
  end

  assign out_valid_o = out_valid_q;
  assign partner_o   = partner_q;
  assign last_o      = last_q;
endmodule

FILE: src/line_crossing_finder_core.sv
// Line crossing finder. Segments arrive longest first; up to keep_count per frame (at most
// SEG_MAX) are stored, and each new one is tested against all stored ones in ascending
// store order while the store has room; one arriving when it is full is dropped untested.
// Each stored partner passes through read, product, sum, angle, point and bound stages; a
// passing pair then goes through a shared restoring divider and an emit step that hands
// the result over. A result is released when the next crossing of the same segment, or
// the end of the scan, is known.
module line_crossing_finder_core #(
  parameter int SEG_MAX    = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lcf_seg_if.sink                       seg_in,
  lcf_cross_if.source                   cross_out,
  input  logic                          cfg_we_i,
  input  logic [lcf_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [lcf_pkg::CfgDataBits-1:0] cfg_data_i
);
  import lcf_pkg::*;

  logic [15:0] tan_min_q, tan_max_q;
  logic [12:0] width_q, height_q;
  logic [6:0]  keep_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tan_min_q <= 16'd305;
      tan_max_q <= 16'd2926;
      width_q   <= 13'd4096;
      height_q  <= 13'd4096;
      keep_q    <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TAN_MIN:      tan_min_q <= cfg_data_i;
        REG_TAN_MAX:      tan_max_q <= cfg_data_i;
        REG_IMAGE_WIDTH:  width_q   <= cfg_data_i[12:0];
        REG_IMAGE_HEIGHT: height_q  <= cfg_data_i[12:0];
        REG_KEEP_COUNT:   keep_q    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  cmd_t  cmd;
  stat_t stat;
  logic [$clog2(SEG_MAX)-1:0] rd_idx, wr_idx;

  lcf_ctrl #(.SegMax(SEG_MAX)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(seg_in.valid), .in_ready_o(seg_in.ready),
    .new_frame_i(seg_in.new_frame), .keep_count_i(keep_q),
    .stat_i(stat), .cmd_o(cmd), .rd_idx_o(rd_idx), .wr_idx_o(wr_idx),
    .out_valid_o(cross_out.valid), .out_ready_i(cross_out.ready),
    .partner_o(cross_out.partner_index), .last_o(cross_out.last_of_run)
  );

  lcf_datapath #(.SegMax(SEG_MAX), .CoordBits(COORD_BITS)) u_dp (
    .clk_i, .cmd_i(cmd), .stat_o(stat), .rd_idx_i(rd_idx), .wr_idx_i(wr_idx),
    .sx_i(seg_in.start_x), .sy_i(seg_in.start_y), .ex_i(seg_in.end_x), .ey_i(seg_in.end_y),
    .tan_min_i(tan_min_q), .tan_max_i(tan_max_q), .width_i(width_q), .height_i(height_q),
    .px_o(cross_out.cross_x), .py_o(cross_out.cross_y)
  );
endmodule
